### src/b64lw_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the alphabet lookup for the Base64 line encoder.
package b64lw_pkg;

    localparam logic [7:0] CHAR_PAD = 8'h3D;
    localparam logic [7:0] CHAR_CR  = 8'h0D;
    localparam logic [7:0] CHAR_LF  = 8'h0A;

    // configuration register indexes
    localparam logic CFG_NO_PAD  = 1'b0;
    localparam logic CFG_NO_CRLF = 1'b1;

    localparam int CMDQ_DEPTH = 4;
    localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);

    // one output burst: a 24-bit group, how many sextets to send, total chars
    typedef struct packed {
        logic [23:0] word;
        logic [2:0]  ndata;
        logic [2:0]  len;
        logic        last;
    } cmd_t;

    function automatic logic [7:0] b64_char(input logic [5:0] v);
        logic [7:0] vx;
        logic [7:0] ch;
        vx = {2'b00, v};
        if (v < 6'd26)
            ch = 8'd65 + vx;
        else if (v < 6'd52)
            ch = 8'd71 + vx;
        else if (v < 6'd62)
            ch = vx - 8'd4;
        else if (v == 6'd62)
            ch = 8'h2B;
        else
            ch = 8'h2F;
        return ch;
    endfunction

endpackage

### src/b64lw_front.sv
`timescale 1ns / 1ps
// Front end: takes bytes, collects groups, tracks line position, issues burst commands.
module b64lw_front
    import b64lw_pkg::*;
#(
    parameter int GROUPS_PER_LINE = 19
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    input  logic       no_pad,
    input  logic       no_crlf,
    output logic       cmd_push,
    output cmd_t       cmd
);

    localparam logic [4:0] GPL = 5'(GROUPS_PER_LINE);

    logic [15:0] held_reg, held_next;
    logic [1:0]  pos_reg, pos_next;
    logic [4:0]  gol_reg, gol_next;
    logic [4:0]  gol_inc;
    logic        wrap;

    assign gol_inc = gol_reg + 5'd1;
    assign wrap    = (gol_inc >= GPL);

    always_comb
    begin
        held_next = held_reg;
        pos_next  = pos_reg;
        gol_next  = gol_reg;
        cmd_push  = 1'b0;
        cmd       = '{word: 24'd0, ndata: 3'd4, len: 3'd4, last: last_byte};
        if (accept)
        begin
            if (pos_reg == 2'd2)
            begin
                cmd_push  = 1'b1;
                cmd.word  = {held_reg, data_byte};
                cmd.ndata = 3'd4;
                cmd.len   = (wrap && !no_crlf) ? 3'd6 : 3'd4;
                held_next = 16'd0;
                pos_next  = 2'd0;
                gol_next  = wrap ? 5'd0 : gol_inc;
            end
            else if (last_byte)
            begin
                // partial final group, padded out to four unless suppressed
                cmd_push = 1'b1;
                if (pos_reg == 2'd1)
                begin
                    cmd.word  = {held_reg[7:0], data_byte, 8'd0};
                    cmd.ndata = 3'd3;
                end
                else
                begin
                    cmd.word  = {data_byte, 16'd0};
                    cmd.ndata = 3'd2;
                end
                cmd.len = no_pad ? cmd.ndata : 3'd4;
            end
            else
            begin
                held_next = {held_reg[7:0], data_byte};
                pos_next  = pos_reg + 2'd1;
            end
            if (last_byte)
            begin
                held_next = 16'd0;
                pos_next  = 2'd0;
                gol_next  = 5'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= 16'd0;
            pos_reg  <= 2'd0;
            gol_reg  <= 5'd0;
        end
        else
        begin
            held_reg <= held_next;
            pos_reg  <= pos_next;
            gol_reg  <= gol_next;
        end
    end

endmodule

### src/b64lw_cmdq.sv
`timescale 1ns / 1ps
// Small command queue between the front end and the character serializer.
module b64lw_cmdq
    import b64lw_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output cmd_t head,
    output logic empty,
    output logic full
);

    cmd_t               mem [CMDQ_DEPTH];
    logic [CMDQ_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CMDQ_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CMDQ_AW:0]   count_reg, count_next;
    logic               do_push, do_pop;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == (CMDQ_AW+1)'(CMDQ_DEPTH));
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### src/b64lw_back.sv
`timescale 1ns / 1ps
// Back end: walks each command one character per cycle into the output register, while that register is free or popped.
module b64lw_back
    import b64lw_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cmd_valid,
    input  cmd_t       cmd,
    output logic       cmd_pop,
    input  logic       pop,
    output logic       empty,
    output logic [7:0] out_char,
    output logic       last_char
);

    logic [2:0] idx_reg, idx_next;
    logic       valid_reg, valid_next;
    logic [7:0] char_reg, char_next;
    logic       lastc_reg, lastc_next;
    logic       can_load;
    logic       final_char;
    logic [5:0] sextet;
    logic [7:0] sel_char;

    assign can_load   = !valid_reg || pop;
    assign final_char = (idx_reg == cmd.len - 3'd1);

    always_comb
    begin
        case (idx_reg[1:0])
            2'd0:    sextet = cmd.word[23:18];
            2'd1:    sextet = cmd.word[17:12];
            2'd2:    sextet = cmd.word[11:6];
            default: sextet = cmd.word[5:0];
        endcase
        case (idx_reg)
            3'd0, 3'd1, 3'd2, 3'd3:
                sel_char = (idx_reg < cmd.ndata) ? b64_char(sextet) : CHAR_PAD;
            3'd4:    sel_char = CHAR_CR;
            default: sel_char = CHAR_LF;
        endcase
    end

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        char_next  = char_reg;
        lastc_next = lastc_reg;
        cmd_pop    = 1'b0;
        if (can_load)
        begin
            valid_next = cmd_valid;
            if (cmd_valid)
            begin
                char_next  = sel_char;
                lastc_next = cmd.last && final_char;
                if (final_char)
                begin
                    idx_next = 3'd0;
                    cmd_pop  = 1'b1;
                end
                else
                    idx_next = idx_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= 3'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg  <= char_next;
        lastc_reg <= lastc_next;
    end

    assign empty     = !valid_reg;
    assign out_char  = char_reg;
    assign last_char = lastc_reg;

endmodule

### src/base64_line_wrapping_encoder.sv
`timescale 1ns / 1ps
// Top level of the streaming Base64 encoder with CR LF line wrapping.
//
//  channel  | handshake         | payload
//  ---------+-------------------+-----------------------
//  input    | push / full       | data_byte, last_byte
//  result   | empty / pop       | out_char, last_char
//  config   | cfg_we            | cfg_index, cfg_data
//
// A byte is taken whenever the command queue has room; a byte
// that closes a group turns into 4 or 6 characters, a final byte into 2 to 4.
// The serializer sends one character per cycle unless the result side stalls,
// so the sustained input rate is set by the characters per group, lower with line breaks.
// A four-entry command queue absorbs bursts; result stalls back up into it.
// Reset clears all control state at once; there is no clearing pass.
module base64_line_wrapping_encoder
    import b64lw_pkg::*;
#(
    parameter int GROUPS_PER_LINE = 19
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] out_char,
    output logic       last_char,
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic       cfg_data
);

    logic no_pad_reg, no_pad_next;
    logic no_crlf_reg, no_crlf_next;
    logic accept;
    logic cmd_push;
    cmd_t cmd_in;
    cmd_t cmd_head;
    logic cmdq_empty, cmdq_full;
    logic cmd_pop;

    assign full   = cmdq_full;
    assign accept = push && !cmdq_full;

    always_comb
    begin
        no_pad_next  = no_pad_reg;
        no_crlf_next = no_crlf_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_NO_PAD:  no_pad_next = cfg_data;
                CFG_NO_CRLF: no_crlf_next = cfg_data;
                default:     no_pad_next = no_pad_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            no_pad_reg  <= 1'b0;
            no_crlf_reg <= 1'b0;
        end
        else
        begin
            no_pad_reg  <= no_pad_next;
            no_crlf_reg <= no_crlf_next;
        end
    end

    b64lw_front #(
        .GROUPS_PER_LINE(GROUPS_PER_LINE)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .data_byte(data_byte),
        .last_byte(last_byte),
        .no_pad   (no_pad_reg),
        .no_crlf  (no_crlf_reg),
        .cmd_push (cmd_push),
        .cmd      (cmd_in)
    );

    b64lw_cmdq u_cmdq (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (cmd_push),
        .push_cmd(cmd_in),
        .pop     (cmd_pop),
        .head    (cmd_head),
        .empty   (cmdq_empty),
        .full    (cmdq_full)
    );

    b64lw_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd_valid(!cmdq_empty),
        .cmd      (cmd_head),
        .cmd_pop  (cmd_pop),
        .pop      (pop),
        .empty    (empty),
        .out_char (out_char),
        .last_char(last_char)
    );

`ifndef ASSERT_OFF
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_push |-> !cmdq_full)
        else $error("command issued into a full queue");

    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> !cmdq_empty)
        else $error("serializer retired a command from an empty queue");

    a_crlf_full_group: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_push && cmd_in.len > 3'd4) |-> (cmd_in.ndata == 3'd4))
        else $error("line break attached to a partial group");
`endif

endmodule

### verif/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the Base64 line-wrapping encoder.
module tb;
    import b64lw_pkg::*;

    localparam int CLK_PERIOD    = 10;
    localparam int LINE_GROUPS   = 19;
    localparam int SETTLE_CYCLES = 16;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int HOLD_CYCLES   = 150;
    localparam int IDLE_PCT      = 21;
    localparam logic [8*64-1:0] ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    typedef struct packed {
        logic [7:0] code;
        logic       last;
    } enc_char_t;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       push      = 1'b0;
    logic [7:0] data_byte = 8'h00;
    logic       last_byte = 1'b0;
    logic       pop       = 1'b0;
    logic       cfg_we    = 1'b0;
    logic       cfg_index = CFG_NO_PAD;
    logic       cfg_data  = 1'b0;
    logic       full;
    logic       empty;
    logic [7:0] out_char;
    logic       last_char;

    // encoder state as the testbench sees it
    logic [15:0] held_pair   = '0;
    logic [1:0]  group_fill  = '0;
    logic [4:0]  line_groups = '0;
    logic        pad_off     = 1'b0;
    logic        crlf_off    = 1'b0;

    enc_char_t pending_chars[$];
    int        mismatch_count = 0;
    bit        tx_idle_on     = 1'b1;
    bit        rx_idle_on     = 1'b1;
    logic      rx_hold        = 1'b0;

    base64_line_wrapping_encoder uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .empty     (empty),
        .pop       (pop),
        .out_char  (out_char),
        .last_char (last_char),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    initial
    begin
        #(CLK_PERIOD * 400000);
        $display("DONE: errors detected");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("%0t MISMATCH: %s", $time, msg);
        mismatch_count++;
    endtask

    function automatic logic [7:0] alpha_char(input logic [5:0] idx);
        return ALPHABET[(63 - idx) * 8 +: 8];
    endfunction

    // advance the encoder state by one byte and queue the characters it yields
    task automatic encode_byte(input logic [7:0] b, input logic fin);
        logic [7:0]  burst[$];
        logic [23:0] grp;
        int          nsext;
        logic        wrap_now;
        enc_char_t   ec;
        grp = '0;
        nsext = 0;
        wrap_now = 1'b0;
        if (group_fill == 2'd2)
        begin
            grp = {held_pair, b};
            nsext = 4;
            held_pair = '0;
            group_fill = '0;
            line_groups = line_groups + 5'd1;
            if (line_groups >= LINE_GROUPS)
            begin
                line_groups = '0;
                wrap_now = 1'b1;
            end
        end
        else if (fin)
        begin
            grp = (group_fill == 2'd1) ? {held_pair[7:0], b, 8'h00} : {b, 16'h0000};
            nsext = (group_fill == 2'd1) ? 3 : 2;
        end
        else
        begin
            held_pair = {held_pair[7:0], b};
            group_fill = group_fill + 2'd1;
        end
        for (int k = 0; k < nsext; k++)
            burst.insert(burst.size(), alpha_char(grp[23 - 6 * k -: 6]));
        if (wrap_now && !crlf_off)
        begin
            burst.insert(burst.size(), CHAR_CR);
            burst.insert(burst.size(), CHAR_LF);
        end
        // padding only on a flushed partial group
        if (fin && nsext != 4 && !pad_off)
            for (int k = nsext; k < 4; k++)
                burst.insert(burst.size(), CHAR_PAD);
        for (int k = 0; k < burst.size(); k++)
        begin
            ec.code = burst[k];
            ec.last = fin && (k == burst.size() - 1);
            pending_chars.insert(pending_chars.size(), ec);
        end
        if (fin)
        begin
            held_pair = '0;
            group_fill = '0;
            line_groups = '0;
        end
    endtask

    always @(posedge clk)
    begin : result_check
        enc_char_t want;
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                if (pending_chars.size() == 0)
                    report_mismatch($sformatf("unexpected char %h", out_char));
                else
                begin
                    want = pending_chars.pop_front();
                    if (out_char !== want.code)
                        report_mismatch($sformatf("out_char got %h want %h",
                                                  out_char, want.code));
                    if (last_char !== want.last)
                        report_mismatch($sformatf("last_char got %b want %b on char %h",
                                                  last_char, want.last, want.code));
                end
            end
            pop <= !rx_hold && !(rx_idle_on && $urandom_range(99) < IDLE_PCT);
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic fin);
        while (tx_idle_on && $urandom_range(99) < IDLE_PCT)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        data_byte <= b;
        last_byte <= fin;
        do
            @(posedge clk);
        while (full);
        encode_byte(b, fin);
    endtask

    // bytes go out most significant first; the lowest byte ends the message
    task automatic send_bytes(input logic [63:0] bytes, input int count);
        for (int i = count - 1; i >= 0; i--)
            send_byte(bytes[8 * i +: 8], i == 0);
    endtask

    task automatic send_message(input int len);
        for (int i = 0; i < len; i++)
            send_byte(8'($urandom_range(255)), i == len - 1);
    endtask

    task automatic wait_for_drain();
        int waited;
        waited = 0;
        push <= 1'b0;
        while (pending_chars.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (pending_chars.size() != 0)
        begin
            report_mismatch($sformatf("%0d chars never came out", pending_chars.size()));
            pending_chars.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_config(input logic no_pad_val, input logic no_crlf_val);
        wait_for_drain();
        cfg_we <= 1'b1;
        cfg_index <= CFG_NO_PAD;
        cfg_data <= no_pad_val;
        @(posedge clk);
        cfg_index <= CFG_NO_CRLF;
        cfg_data <= no_crlf_val;
        @(posedge clk);
        cfg_we <= 1'b0;
        pad_off = no_pad_val;
        crlf_off = no_crlf_val;
    endtask

    // field extremes, both partial group sizes, '+' and '/', with and without padding
    task automatic test_directed_messages();
        write_config(1'b0, 1'b0);
        send_bytes(64'h00, 1);
        send_bytes(64'hFF, 1);
        send_bytes(64'hFF00, 2);
        send_bytes(64'h00FF80, 3);
        send_bytes(64'hFBFFBF, 3);
        send_bytes(64'h9ABCDEF011, 5);
        write_config(1'b1, 1'b0);
        send_bytes(64'hFF, 1);
        send_bytes(64'hFF00, 2);
        send_bytes(64'h00FF807F, 4);
    endtask

    // one full line that ends the message, sent with no idling on either side
    task automatic test_line_wrap();
        write_config(1'b0, 1'b0);
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        send_message(57);
        wait_for_drain();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    // result side held off long enough for the block to fill and stall its input
    task automatic test_result_stall();
        write_config(1'b0, 1'b0);
        tx_idle_on = 1'b0;
        fork
            begin
                rx_hold <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                rx_hold <= 1'b0;
            end
            begin
                send_message(15);
            end
        join
        tx_idle_on = 1'b1;
        wait_for_drain();
    endtask

    task automatic test_random_messages();
        int sent;
        int len;
        for (int phase = 0; phase < 2; phase++)
        begin
            if (phase == 0)
                write_config(1'b0, 1'b1);
            else
                write_config(1'($urandom_range(1)), 1'($urandom_range(1)));
            sent = 0;
            while (sent < 6)
            begin
                len = $urandom_range(1, 5);
                send_message(len);
                sent += len;
            end
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_messages();
        test_line_wrap();
        test_result_stall();
        test_random_messages();
        wait_for_drain();
        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
